[rtl/mipsx_pkg.sv]
// ============================================================================
// mipsx_pkg
// Shared types and constants for the MIPS subset execute and PC block:
// opcode and function codes, the decoded instruction and the result beat.
// ============================================================================
package mipsx_pkg;

    // Field widths fixed by the instruction format.
    localparam int OPC_W    = 6;
    localparam int REG_IDX_W = 5;
    localparam int IMM_W    = 16;
    localparam int TGT_W    = 26;
    localparam int WORD_W   = 32;
    localparam int PLEN_W   = 17;
    localparam int MIDX_W   = 8;
    localparam int REG_COUNT = 32;

    // Opcodes.
    localparam logic [OPC_W-1:0] OPC_RTYPE = 6'd0;
    localparam logic [OPC_W-1:0] OPC_J     = 6'd2;
    localparam logic [OPC_W-1:0] OPC_BEQ   = 6'd4;
    localparam logic [OPC_W-1:0] OPC_ADDI  = 6'd8;
    localparam logic [OPC_W-1:0] OPC_LW    = 6'd35;
    localparam logic [OPC_W-1:0] OPC_SW    = 6'd43;

    // R-type function codes.
    localparam logic [OPC_W-1:0] FN_ADD = 6'd32;
    localparam logic [OPC_W-1:0] FN_SUB = 6'd34;
    localparam logic [OPC_W-1:0] FN_AND = 6'd36;
    localparam logic [OPC_W-1:0] FN_OR  = 6'd37;
    localparam logic [OPC_W-1:0] FN_SLT = 6'd42;

    // Instruction class as seen by the back end.
    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_ALU,
        CLS_ADDI,
        CLS_LW,
        CLS_SW,
        CLS_BEQ,
        CLS_J
    } cls_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_SLT
    } alu_t;

    // Decoded instruction held in the queue between front and back.
    typedef struct packed {
        cls_t                   cls;
        alu_t                   alu;
        logic [REG_IDX_W-1:0]   rs;
        logic [REG_IDX_W-1:0]   rt;
        logic [REG_IDX_W-1:0]   dest;
        logic                   writes;
        logic signed [IMM_W-1:0] imm;
        logic [TGT_W-1:0]       target;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [WORD_W-1:0]        next_pc;
        logic                     finished;
        logic                     reg_written;
        logic [REG_IDX_W-1:0]     reg_write_index;
        logic signed [WORD_W-1:0] reg_write_value;
        logic                     mem_written;
        logic [MIDX_W-1:0]        mem_word_index;
        logic signed [WORD_W-1:0] mem_write_value;
        logic                     branch_taken;
    } result_t;

endpackage

[rtl/mipsx_fifo.sv]
// ============================================================================
// mipsx_fifo
// Two-entry first-in first-out queue with push/full and pop/empty sides.
// ============================================================================
module mipsx_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    // Handshake qualification.
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/mipsx_front.sv]
// ============================================================================
// mipsx_front
// Accepts instruction beats, classifies them and queues the decoded form
// for the execute back end.
// ============================================================================
module mipsx_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [mipsx_pkg::OPC_W-1:0]            command,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]        rs_index,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]        rt_index,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]        rd_index,
    input  logic [mipsx_pkg::OPC_W-1:0]            function_code,
    input  logic signed [mipsx_pkg::IMM_W-1:0]     immediate,
    input  logic [mipsx_pkg::TGT_W-1:0]            jump_target,
    input  logic                                   clearing,
    output mipsx_pkg::item_t                       item,
    output logic                                   item_empty,
    input  logic                                   item_pop
);
    import mipsx_pkg::*;

    item_t dec;
    logic  q_full;
    logic  wr_class;

    // Classify the opcode and pick the destination register.
    always_comb
    begin
        dec.cls    = CLS_NOP;
        dec.alu    = ALU_ADD;
        dec.rs     = rs_index;
        dec.rt     = rt_index;
        dec.dest   = rt_index;
        dec.imm    = immediate;
        dec.target = jump_target;
        wr_class   = 1'b0;
        unique case (command)
            OPC_ADDI:
            begin
                dec.cls  = CLS_ADDI;
                wr_class = 1'b1;
            end
            OPC_LW:
            begin
                dec.cls  = CLS_LW;
                wr_class = 1'b1;
            end
            OPC_SW:  dec.cls = CLS_SW;
            OPC_BEQ: dec.cls = CLS_BEQ;
            OPC_J:   dec.cls = CLS_J;
            OPC_RTYPE:
            begin
                dec.dest = rd_index;
                wr_class = 1'b1;
                dec.cls  = CLS_ALU;
                unique case (function_code)
                    FN_ADD:  dec.alu = ALU_ADD;
                    FN_SUB:  dec.alu = ALU_SUB;
                    FN_AND:  dec.alu = ALU_AND;
                    FN_OR:   dec.alu = ALU_OR;
                    FN_SLT:  dec.alu = ALU_SLT;
                    default:
                    begin
                        // An unknown function does nothing but advance the PC.
                        dec.cls  = CLS_NOP;
                        wr_class = 1'b0;
                    end
                endcase
            end
            default: dec.cls = CLS_NOP;
        endcase
        // Register zero is never written.
        dec.writes = wr_class && (dec.dest != '0);
    end

    // Nothing is taken while the data memory is being cleared.
    assign full = q_full || clearing;

    mipsx_fifo #(
        .WIDTH ($bits(item_t))
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .wdata (dec),
        .full  (q_full),
        .pop   (item_pop),
        .rdata (item),
        .empty (item_empty)
    );

endmodule

[rtl/mipsx_back.sv]
// ============================================================================
// mipsx_back
// Execute back end: register file, data memory, ALU, address generation and
// program counter. Takes one decoded instruction at a time from the queue.
// ============================================================================
module mipsx_back #(
    parameter int DATA_WORDS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mipsx_pkg::PLEN_W-1:0]      program_length,
    input  mipsx_pkg::item_t                  item,
    input  logic                              item_empty,
    output logic                              item_pop,
    output mipsx_pkg::result_t                res,
    output logic                              res_push,
    input  logic                              res_full,
    output logic                              clearing
);
    import mipsx_pkg::*;

    localparam int IDX_W = $clog2(DATA_WORDS);

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_READ  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LOAD  = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    item_t                   item_reg;
    logic [WORD_W-1:0]       pc_reg;
    logic [IDX_W-1:0]        clr_reg;
    logic [WORD_W-1:0]       rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0]    rf_valid_reg;
    logic [WORD_W-1:0]       a_rdata_reg;
    logic [WORD_W-1:0]       b_rdata_reg;
    logic                    a_valid_reg;
    logic                    b_valid_reg;
    logic [WORD_W-1:0]       dmem [DATA_WORDS];
    logic [WORD_W-1:0]       dm_rdata_reg;
    result_t                 hold_reg;

    logic [WORD_W-1:0]       a_val;
    logic [WORD_W-1:0]       b_val;
    logic [WORD_W-1:0]       imm32;
    logic [WORD_W-1:0]       sum;
    logic [IDX_W-1:0]        idx_c;
    logic [IDX_W+MIDX_W-1:0] idx_ext;
    logic [WORD_W-1:0]       alu_val;
    logic [WORD_W-1:0]       wval_c;
    logic [WORD_W-1:0]       pc_next_c;
    logic                    equal_c;
    logic                    taken_c;
    logic                    is_mem;
    logic                    exec_fire;
    result_t                 res_c;
    logic                    rf_we;
    logic [WORD_W-1:0]       rf_wdata;
    logic                    dm_we;
    logic [IDX_W-1:0]        dm_waddr;
    logic [WORD_W-1:0]       dm_wdata;

    // Operands; an entry never written reads as zero.
    assign a_val = a_valid_reg ? a_rdata_reg : '0;
    assign b_val = b_valid_reg ? b_rdata_reg : '0;
    assign imm32 = {{(WORD_W-IMM_W){item_reg.imm[IMM_W-1]}}, item_reg.imm};
    assign sum   = a_val + imm32;

    // Word index: divide by four rounding toward zero, keep the low bits.
    assign idx_c   = sum[IDX_W+1:2] + IDX_W'(sum[WORD_W-1] && (sum[1:0] != 2'b00));
    assign idx_ext = {{MIDX_W{1'b0}}, idx_c};

    // Register-register operations.
    always_comb
    begin
        unique case (item_reg.alu)
            ALU_ADD: alu_val = a_val + b_val;
            ALU_SUB: alu_val = a_val - b_val;
            ALU_AND: alu_val = a_val & b_val;
            ALU_OR:  alu_val = a_val | b_val;
            ALU_SLT: alu_val = {{(WORD_W-1){1'b0}}, ($signed(a_val) < $signed(b_val))};
            default: alu_val = '0;
        endcase
    end

    // Register write value, next PC and branch outcome.
    assign equal_c = (a_val == b_val);
    assign is_mem  = (item_reg.cls == CLS_LW) || (item_reg.cls == CLS_SW);

    always_comb
    begin
        wval_c    = '0;
        pc_next_c = pc_reg + 32'd1;
        taken_c   = 1'b0;
        unique case (item_reg.cls)
            CLS_ADDI: wval_c = sum;
            CLS_ALU:  wval_c = alu_val;
            CLS_BEQ:
            begin
                if (equal_c)
                begin
                    pc_next_c = pc_reg + imm32 + 32'd1;
                    taken_c   = 1'b1;
                end
            end
            CLS_J:
            begin
                pc_next_c = {{(WORD_W-TGT_W){1'b0}}, item_reg.target};
                taken_c   = 1'b1;
            end
            default: wval_c = '0;
        endcase
    end

    // Result beat as built in the execute cycle.
    always_comb
    begin
        res_c.next_pc         = pc_next_c;
        res_c.finished        = (pc_next_c >= {{(WORD_W-PLEN_W){1'b0}}, program_length});
        res_c.reg_written     = item_reg.writes;
        res_c.reg_write_index = item_reg.writes ? item_reg.dest : '0;
        res_c.reg_write_value = item_reg.writes ? wval_c : '0;
        res_c.mem_written     = (item_reg.cls == CLS_SW);
        res_c.mem_word_index  = is_mem ? idx_ext[MIDX_W-1:0] : '0;
        res_c.mem_write_value = (item_reg.cls == CLS_SW) ? b_val : '0;
        res_c.branch_taken    = taken_c;
    end

    // Handshakes with the queues on both sides.
    assign exec_fire = (state_reg == S_EXEC) && !res_full;
    assign item_pop  = (state_reg == S_READ) && !item_empty;
    assign clearing  = (state_reg == S_CLEAR);
    assign res_push  = (exec_fire && (item_reg.cls != CLS_LW)) || (state_reg == S_LOAD);

    always_comb
    begin
        res = res_c;
        if (state_reg == S_LOAD)
        begin
            res = hold_reg;
            res.reg_write_value = hold_reg.reg_written ? dm_rdata_reg : '0;
        end
    end

    // Write ports of the register file and the data memory.
    assign rf_we = (exec_fire && item_reg.writes && (item_reg.cls != CLS_LW))
                || ((state_reg == S_LOAD) && item_reg.writes);
    assign rf_wdata = (state_reg == S_LOAD) ? dm_rdata_reg : wval_c;
    assign dm_we    = clearing || (exec_fire && (item_reg.cls == CLS_SW));
    assign dm_waddr = clearing ? clr_reg : idx_c;
    assign dm_wdata = clearing ? '0 : b_val;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == IDX_W'(DATA_WORDS - 1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (!item_empty)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = (item_reg.cls == CLS_LW) ? S_LOAD : S_READ;
                end
            end
            S_LOAD:  state_next = S_READ;
            default: state_next = S_CLEAR;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            pc_reg       <= '0;
            rf_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (exec_fire)
            begin
                pc_reg <= pc_next_c;
            end
            if (rf_we)
            begin
                rf_valid_reg[item_reg.dest] <= 1'b1;
            end
        end
    end

    // Instruction capture, operand read and held load result.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            item_reg    <= item;
            a_rdata_reg <= rf_mem[item.rs];
            b_rdata_reg <= rf_mem[item.rt];
            a_valid_reg <= rf_valid_reg[item.rs];
            b_valid_reg <= rf_valid_reg[item.rt];
        end
        if (exec_fire)
        begin
            hold_reg <= res_c;
        end
    end

    // Register file write port.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[item_reg.dest] <= rf_wdata;
        end
    end

    // Data memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if (exec_fire)
        begin
            dm_rdata_reg <= dmem[idx_c];
        end
    end

endmodule

[rtl/mips_subset_execute_and_pc.sv]
// ============================================================================
// mips_subset_execute_and_pc
// Execute stage and instruction-index program counter of a small MIPS32
// subset: ADDI, LW, SW, BEQ, J and R-type ADD/SUB/AND/OR/SLT.
// ============================================================================
// Each decoded instruction pushed in gives one result beat reporting the
// register and memory writes, the new PC and whether it lies past the end of
// the program. In the execute back end an instruction passes through a read
// state (register file read) and an execute state (compute and write back),
// and a load adds a state for the registered data memory read; the next
// instruction starts only after the previous one has written back, so that
// loop sets the rate. A two-entry queue in front and another on the result
// side keep both ports moving while the other stalls. After reset the data
// memory is zeroed in a pass over all DATA_WORDS words during which full stays
// high; configuration writes are accepted at any time. DATA_WORDS must be a
// power of two, since the word index keeps the low address bits.
module mips_subset_execute_and_pc #(
    parameter int DATA_WORDS = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [mipsx_pkg::OPC_W-1:0]            command,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]        rs_index,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]        rt_index,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]        rd_index,
    input  logic [mipsx_pkg::OPC_W-1:0]            function_code,
    input  logic signed [mipsx_pkg::IMM_W-1:0]     immediate,
    input  logic [mipsx_pkg::TGT_W-1:0]            jump_target,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mipsx_pkg::PLEN_W-1:0]           cfg_data,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [mipsx_pkg::WORD_W-1:0]           next_pc,
    output logic                                   finished,
    output logic                                   reg_written,
    output logic [mipsx_pkg::REG_IDX_W-1:0]        reg_write_index,
    output logic signed [mipsx_pkg::WORD_W-1:0]    reg_write_value,
    output logic                                   mem_written,
    output logic [mipsx_pkg::MIDX_W-1:0]           mem_word_index,
    output logic signed [mipsx_pkg::WORD_W-1:0]    mem_write_value,
    output logic                                   branch_taken
);
    import mipsx_pkg::*;

    logic [PLEN_W-1:0] program_length_reg;
    item_t             item;
    logic              item_empty;
    logic              item_pop;
    result_t           res;
    logic              res_push;
    logic              res_full;
    logic              clearing;
    result_t           out_beat;

    // Program length register; always ready for a beat.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            program_length_reg <= cfg_data;
        end
    end

    // Front end: decode and instruction queue.
    mipsx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .rs_index      (rs_index),
        .rt_index      (rt_index),
        .rd_index      (rd_index),
        .function_code (function_code),
        .immediate     (immediate),
        .jump_target   (jump_target),
        .clearing      (clearing),
        .item          (item),
        .item_empty    (item_empty),
        .item_pop      (item_pop)
    );

    // Back end: execution and state.
    mipsx_back #(
        .DATA_WORDS (DATA_WORDS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .program_length (program_length_reg),
        .item           (item),
        .item_empty     (item_empty),
        .item_pop       (item_pop),
        .res            (res),
        .res_push       (res_push),
        .res_full       (res_full),
        .clearing       (clearing)
    );

    // Result queue.
    mipsx_fifo #(
        .WIDTH ($bits(result_t))
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_beat),
        .empty (empty)
    );

    assign next_pc         = out_beat.next_pc;
    assign finished        = out_beat.finished;
    assign reg_written     = out_beat.reg_written;
    assign reg_write_index = out_beat.reg_write_index;
    assign reg_write_value = out_beat.reg_write_value;
    assign mem_written     = out_beat.mem_written;
    assign mem_word_index  = out_beat.mem_word_index;
    assign mem_write_value = out_beat.mem_write_value;
    assign branch_taken    = out_beat.branch_taken;

    // The back end never offers a result the queue cannot take.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // While the data memory is cleared no instruction is taken or executed.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> (full && !item_pop))
        else $error("instruction taken during memory clearing");

    // Register zero is never reported as written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.reg_written) |-> (res.reg_write_index != '0))
        else $error("write to register zero reported");

    // A result without a register write carries zero index and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.reg_written)
            |-> ((res.reg_write_index == '0) && (res.reg_write_value == '0)))
        else $error("unused register write fields not zero");

endmodule

[tb/mips_subset_execute_and_pc_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// mips_subset_execute_and_pc_checker
// Watches the instruction, configuration and result channels of the MIPS
// subset execute block. It keeps its own register file, data memory, program
// counter and program length, and works out the result of every accepted
// instruction. It then compares each result beat, field by field, with the
// oldest awaited result.
// ============================================================================
module mips_subset_execute_and_pc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic [mipsx_pkg::OPC_W-1:0]         command,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]     rs_index,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]     rt_index,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]     rd_index,
    input  logic [mipsx_pkg::OPC_W-1:0]         function_code,
    input  logic [mipsx_pkg::IMM_W-1:0]         immediate,
    input  logic [mipsx_pkg::TGT_W-1:0]         jump_target,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [mipsx_pkg::PLEN_W-1:0]        cfg_data,
    input  logic                                empty,
    input  logic                                pop,
    input  logic [mipsx_pkg::WORD_W-1:0]        next_pc,
    input  logic                                finished,
    input  logic                                reg_written,
    input  logic [mipsx_pkg::REG_IDX_W-1:0]     reg_write_index,
    input  logic [mipsx_pkg::WORD_W-1:0]        reg_write_value,
    input  logic                                mem_written,
    input  logic [mipsx_pkg::MIDX_W-1:0]        mem_word_index,
    input  logic [mipsx_pkg::WORD_W-1:0]        mem_write_value,
    input  logic                                branch_taken,
    output int                                  failures,
    output int                                  pending
);
    import mipsx_pkg::*;

    localparam int MEM_WORDS = 256;

    // Shadow copy of the architectural state.
    logic [WORD_W-1:0] shadow_regs [REG_COUNT];
    logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
    logic [WORD_W-1:0] shadow_pc;
    logic [PLEN_W-1:0] shadow_plen;

    result_t awaited_results[$];
    int      mismatch_count;

    // Word index of base plus offset: divide by four, rounding toward zero,
    // and keep the low address bits.
    function automatic logic [MIDX_W-1:0] word_index_of(logic [WORD_W-1:0] base,
                                                        logic [WORD_W-1:0] offset);
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] quotient;
        sum = base + offset;
        if (sum[WORD_W-1])
        begin
            quotient = '0 - (('0 - sum) >> 2);
        end
        else
        begin
            quotient = sum >> 2;
        end
        return quotient[MIDX_W-1:0];
    endfunction

    // Executes one instruction on the shadow state and returns its result.
    function automatic result_t execute_instruction(logic [OPC_W-1:0] opc,
                                                    logic [REG_IDX_W-1:0] rs,
                                                    logic [REG_IDX_W-1:0] rt,
                                                    logic [REG_IDX_W-1:0] rd,
                                                    logic [OPC_W-1:0] fn,
                                                    logic [IMM_W-1:0] imm,
                                                    logic [TGT_W-1:0] tgt);
        result_t           res;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
        logic [WORD_W-1:0] imm_ext;
        logic [WORD_W-1:0] new_pc;
        logic              writes_reg;
        res        = '0;
        op_a       = shadow_regs[rs];
        op_b       = shadow_regs[rt];
        imm_ext    = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
        new_pc     = shadow_pc + 1;
        writes_reg = 1'b0;
        case (opc)
            OPC_ADDI:
            begin
                res.reg_write_index = rt;
                res.reg_write_value = op_a + imm_ext;
                writes_reg          = 1'b1;
            end
            OPC_LW:
            begin
                res.mem_word_index  = word_index_of(op_a, imm_ext);
                res.reg_write_index = rt;
                res.reg_write_value = shadow_mem[res.mem_word_index];
                writes_reg          = 1'b1;
            end
            OPC_SW:
            begin
                res.mem_word_index  = word_index_of(op_a, imm_ext);
                res.mem_write_value = op_b;
                res.mem_written     = 1'b1;
                shadow_mem[res.mem_word_index] = op_b;
            end
            OPC_BEQ:
            begin
                if (op_a == op_b)
                begin
                    new_pc           = shadow_pc + imm_ext + 1;
                    res.branch_taken = 1'b1;
                end
            end
            OPC_J:
            begin
                new_pc           = {{(WORD_W-TGT_W){1'b0}}, tgt};
                res.branch_taken = 1'b1;
            end
            OPC_RTYPE:
            begin
                res.reg_write_index = rd;
                writes_reg          = 1'b1;
                case (fn)
                    FN_ADD: res.reg_write_value = op_a + op_b;
                    FN_SUB: res.reg_write_value = op_a - op_b;
                    FN_AND: res.reg_write_value = op_a & op_b;
                    FN_OR:  res.reg_write_value = op_a | op_b;
                    FN_SLT: res.reg_write_value = ($signed(op_a) < $signed(op_b)) ? 1 : 0;
                    default: writes_reg = 1'b0;
                endcase
            end
            default: ;
        endcase
        // Writes to register zero are dropped and leave the write fields clear.
        if (writes_reg && res.reg_write_index != '0)
        begin
            shadow_regs[res.reg_write_index] = res.reg_write_value;
            res.reg_written = 1'b1;
        end
        else
        begin
            res.reg_write_index = '0;
            res.reg_write_value = '0;
        end
        shadow_pc    = new_pc;
        res.next_pc  = new_pc;
        res.finished = (new_pc >= {{(WORD_W-PLEN_W){1'b0}}, shadow_plen});
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] seen,
                                   logic [WORD_W-1:0] wanted);
        $display("%0t: result mismatch on %s: got 0x%08h, expected 0x%08h",
                 $time, what, seen, wanted);
        mismatch_count++;
    endtask

    // Channel monitor: results are checked first, then new instructions and
    // configuration writes update the shadow state.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                shadow_regs[i] = '0;
            end
            for (int i = 0; i < MEM_WORDS; i++)
            begin
                shadow_mem[i] = '0;
            end
            shadow_pc   = '0;
            shadow_plen = '0;
            awaited_results.delete();
            mismatch_count = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            result_t want;
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected beat, next_pc", next_pc, '0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (next_pc !== want.next_pc)
                        report_mismatch("next_pc", next_pc, want.next_pc);
                    if (finished !== want.finished)
                        report_mismatch("finished", WORD_W'(finished),
                                        WORD_W'(want.finished));
                    if (reg_written !== want.reg_written)
                        report_mismatch("reg_written", WORD_W'(reg_written),
                                        WORD_W'(want.reg_written));
                    if (reg_write_index !== want.reg_write_index)
                        report_mismatch("reg_write_index", WORD_W'(reg_write_index),
                                        WORD_W'(want.reg_write_index));
                    if (reg_write_value !== want.reg_write_value)
                        report_mismatch("reg_write_value", reg_write_value,
                                        want.reg_write_value);
                    if (mem_written !== want.mem_written)
                        report_mismatch("mem_written", WORD_W'(mem_written),
                                        WORD_W'(want.mem_written));
                    if (mem_word_index !== want.mem_word_index)
                        report_mismatch("mem_word_index", WORD_W'(mem_word_index),
                                        WORD_W'(want.mem_word_index));
                    if (mem_write_value !== want.mem_write_value)
                        report_mismatch("mem_write_value", mem_write_value,
                                        want.mem_write_value);
                    if (branch_taken !== want.branch_taken)
                        report_mismatch("branch_taken", WORD_W'(branch_taken),
                                        WORD_W'(want.branch_taken));
                end
            end
            if (push && !full)
            begin
                awaited_results.push_back(execute_instruction(command, rs_index, rt_index,
                                                              rd_index, function_code,
                                                              immediate, jump_target));
            end
            if (cfg_valid && cfg_ready)
            begin
                shadow_plen = cfg_data;
            end
            failures <= mismatch_count;
            pending  <= awaited_results.size();
        end
    end

endmodule

[tb/tb_mips_subset_execute_and_pc.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_mips_subset_execute_and_pc
// Drives the MIPS subset execute block with a short directed program and
// then with random instruction streams under several program lengths, with
// random gaps on the instruction side and random stalls on the result side.
// The checker beside the block predicts and compares every result beat.
// ============================================================================
module tb_mips_subset_execute_and_pc;

    import mipsx_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 220;
    localparam int SETTLE_CYCLES = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [OPC_W-1:0]       command;
    logic [REG_IDX_W-1:0]   rs_index;
    logic [REG_IDX_W-1:0]   rt_index;
    logic [REG_IDX_W-1:0]   rd_index;
    logic [OPC_W-1:0]       function_code;
    logic [IMM_W-1:0]       immediate;
    logic [TGT_W-1:0]       jump_target;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [PLEN_W-1:0]      cfg_data;
    logic                   empty;
    logic                   pop;
    logic [WORD_W-1:0]      next_pc;
    logic                   finished;
    logic                   reg_written;
    logic [REG_IDX_W-1:0]   reg_write_index;
    logic [WORD_W-1:0]      reg_write_value;
    logic                   mem_written;
    logic [MIDX_W-1:0]      mem_word_index;
    logic [WORD_W-1:0]      mem_write_value;
    logic                   branch_taken;

    int failures;
    int pending;
    int cycle_count;
    int instr_count;
    int beat_count;
    bit quiet_push;
    bit quiet_pop;

    mips_subset_execute_and_pc uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .rs_index        (rs_index),
        .rt_index        (rt_index),
        .rd_index        (rd_index),
        .function_code   (function_code),
        .immediate       (immediate),
        .jump_target     (jump_target),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .empty           (empty),
        .pop             (pop),
        .next_pc         (next_pc),
        .finished        (finished),
        .reg_written     (reg_written),
        .reg_write_index (reg_write_index),
        .reg_write_value (reg_write_value),
        .mem_written     (mem_written),
        .mem_word_index  (mem_word_index),
        .mem_write_value (mem_write_value),
        .branch_taken    (branch_taken)
    );

    mips_subset_execute_and_pc_checker exec_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .rs_index        (rs_index),
        .rt_index        (rt_index),
        .rd_index        (rd_index),
        .function_code   (function_code),
        .immediate       (immediate),
        .jump_target     (jump_target),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .empty           (empty),
        .pop             (pop),
        .next_pc         (next_pc),
        .finished        (finished),
        .reg_written     (reg_written),
        .reg_write_index (reg_write_index),
        .reg_write_value (reg_write_value),
        .mem_written     (mem_written),
        .mem_word_index  (mem_word_index),
        .mem_write_value (mem_write_value),
        .branch_taken    (branch_taken),
        .failures        (failures),
        .pending         (pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one instruction beat after a random gap, and returns at the
    // falling edge after it was accepted with push still high.
    task automatic send_instr(logic [OPC_W-1:0] opc, logic [REG_IDX_W-1:0] rs,
                              logic [REG_IDX_W-1:0] rt, logic [REG_IDX_W-1:0] rd,
                              logic [OPC_W-1:0] fn, logic [IMM_W-1:0] imm,
                              logic [TGT_W-1:0] tgt);
        int gap;
        if (instr_count % 32 == 0)
        begin
            quiet_push = ($urandom_range(3, 0) == 0);
        end
        instr_count++;
        gap = quiet_push ? 0 : $urandom_range(7, 0);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command       = opc;
        rs_index      = rs;
        rt_index      = rt;
        rd_index      = rd;
        function_code = fn;
        immediate     = imm;
        jump_target   = tgt;
        push          = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full);
        @(negedge clk);
    endtask

    // Writes the program length once every awaited result has come back.
    task automatic set_program_length(logic [PLEN_W-1:0] length);
        push = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data  = length;
        cfg_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Register indices lean towards a few low registers so that values
    // chain, grow and compare equal often enough.
    function automatic logic [REG_IDX_W-1:0] pick_reg();
        if ($urandom_range(1, 0) == 1)
            return REG_IDX_W'($urandom_range(3, 0));
        return REG_IDX_W'($urandom_range(31, 0));
    endfunction

    function automatic logic [IMM_W-1:0] pick_imm();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel < 4)
            return IMM_W'($urandom_range(16, 0) - 8);
        if (sel < 6)
            return IMM_W'($urandom_range(2048, 0) - 1024);
        if (sel == 6)
            return 16'h7FFF;
        if (sel == 7)
            return 16'h8000;
        return IMM_W'($urandom_range(65535, 0));
    endfunction

    // One random instruction, mostly well formed with random operands.
    task automatic send_random_instr();
        logic [OPC_W-1:0] opc;
        logic [OPC_W-1:0] fn;
        logic [TGT_W-1:0] tgt;
        int               sel;
        sel = $urandom_range(99, 0);
        if (sel < 20)
            opc = OPC_ADDI;
        else if (sel < 45)
            opc = OPC_RTYPE;
        else if (sel < 60)
            opc = OPC_LW;
        else if (sel < 75)
            opc = OPC_SW;
        else if (sel < 85)
            opc = OPC_BEQ;
        else if (sel < 90)
            opc = OPC_J;
        else
            opc = OPC_W'($urandom_range(63, 0));
        case ($urandom_range(5, 0))
            0: fn = FN_ADD;
            1: fn = FN_SUB;
            2: fn = FN_AND;
            3: fn = FN_OR;
            4: fn = FN_SLT;
            default: fn = OPC_W'($urandom_range(63, 0));
        endcase
        // Jump targets mostly stay below 70000, near the largest program lengths.
        if ($urandom_range(3, 0) == 0)
            tgt = {16'($urandom_range(16'hFFFF, 0)), 10'($urandom_range(10'h3FF, 0))};
        else
            tgt = TGT_W'($urandom_range(70000, 0));
        send_instr(opc, pick_reg(), pick_reg(), pick_reg(), fn, pick_imm(), tgt);
    endtask

    // Result side: pop after a random stall per beat.
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (beat_count % 32 == 0)
            begin
                quiet_pop = ($urandom_range(3, 0) == 0);
            end
            beat_count++;
            stall = quiet_pop ? 0 : $urandom_range(7, 0);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (empty);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [PLEN_W-1:0] lengths [5];
        instr_count   = 0;
        quiet_push    = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        command       = '0;
        rs_index      = '0;
        rt_index      = '0;
        rd_index      = '0;
        function_code = '0;
        immediate     = '0;
        jump_target   = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed program: operand extremes, every operation, dropped writes
        // to register zero, unknown codes, negative addresses and a PC that
        // wraps around zero.
        set_program_length(20);
        send_instr(OPC_ADDI, 0, 1, 0, 0, 16'h7FFF, 0);
        send_instr(OPC_ADDI, 0, 2, 0, 0, 16'h8000, 0);
        send_instr(OPC_ADDI, 1, 0, 0, 0, 5, 0);
        send_instr(OPC_RTYPE, 1, 2, 3, FN_ADD, 0, 0);
        send_instr(OPC_RTYPE, 2, 1, 4, FN_SUB, 0, 0);
        send_instr(OPC_RTYPE, 1, 2, 5, FN_AND, 0, 0);
        send_instr(OPC_RTYPE, 1, 2, 6, FN_OR, 0, 0);
        send_instr(OPC_RTYPE, 2, 1, 7, FN_SLT, 0, 0);
        send_instr(OPC_RTYPE, 1, 2, 8, FN_SLT, 0, 0);
        send_instr(OPC_RTYPE, 1, 2, 9, 6'd0, 0, 0);
        send_instr(OPC_RTYPE, 31, 31, 31, 6'h3F, 16'hFFFF, 26'h3FFFFFF);
        send_instr(6'h3F, 31, 31, 31, 6'h3F, 16'hFFFF, 26'h3FFFFFF);
        send_instr(OPC_SW, 0, 1, 0, 0, -16'sd5, 0);
        send_instr(OPC_SW, 2, 4, 0, 0, -16'sd1, 0);
        send_instr(OPC_LW, 0, 10, 0, 0, -16'sd5, 0);
        send_instr(OPC_LW, 2, 0, 0, 0, -16'sd1, 0);
        send_instr(OPC_LW, 1, 11, 0, 0, 1020, 0);
        send_instr(OPC_BEQ, 1, 2, 0, 0, 3, 0);
        send_instr(OPC_BEQ, 0, 0, 0, 0, 5, 0);
        send_instr(OPC_J, 0, 0, 0, 0, 0, 26'h3FFFFFF);
        send_instr(OPC_J, 0, 0, 0, 0, 0, 0);
        send_instr(OPC_BEQ, 0, 0, 0, 0, -16'sd2, 0);
        send_instr(OPC_ADDI, 0, 12, 0, 0, 1, 0);
        send_instr(6'd1, 0, 0, 0, 0, 0, 0);

        // Random streams under several program lengths, the extremes among them.
        lengths[0] = 17'd65536;
        lengths[1] = 17'd0;
        lengths[2] = 17'd1;
        lengths[3] = 17'd65535;
        lengths[4] = PLEN_W'($urandom_range(65534, 2));
        for (int phase = 0; phase < 5; phase++)
        begin
            set_program_length(lengths[phase]);
            repeat (PHASE_ITEMS) send_random_instr();
        end
        push = 1'b0;

        // Drain and let any stray beat show up before the verdict.
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
